/* rtl/lmc_pkg.sv */
package lmc_pkg;

    // sizing
    localparam int CHANNELS       = 4;
    localparam int MAX_DATA_BYTES = 8;
    localparam int CH_W           = 2;
    localparam int CH_SLOTS       = 1 << CH_W;
    localparam int LEN_W          = 4;
    localparam int DATA_W         = 64;
    localparam int DATA_LANES     = DATA_W / 8;
    localparam int CFG_W          = 8;
    localparam int CFG_AW         = 2;

    localparam logic [5:0] ID_MASK    = 6'h3F;
    localparam logic       PARITY_INV = 1'b1;

    // command codes
    localparam logic [1:0] CMD_SEND  = 2'd0;
    localparam logic [1:0] CMD_POLL  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // frame directions
    localparam logic [2:0] DIR_MASTER    = 3'd0;
    localparam logic [2:0] DIR_SLAVE     = 3'd1;
    localparam logic [2:0] DIR_S2S       = 3'd2;
    localparam logic [2:0] DIR_RESP_DATA = 3'd3;

    // received frame kinds
    localparam logic [1:0] RX_NONE   = 2'd0;
    localparam logic [1:0] RX_HEADER = 2'd1;
    localparam logic [1:0] RX_DATA   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // reported status
    localparam logic [2:0] STAT_NOT_READY = 3'd0;
    localparam logic [2:0] STAT_OPER      = 3'd1;
    localparam logic [2:0] STAT_TX_BUSY   = 3'd2;
    localparam logic [2:0] STAT_TX_OK     = 3'd3;
    localparam logic [2:0] STAT_RX_NORESP = 3'd4;
    localparam logic [2:0] STAT_RX_OK     = 3'd5;

    // configuration register indices
    localparam logic [CFG_AW-1:0] REG_ENABLE      = 2'd0;
    localparam logic [CFG_AW-1:0] REG_HEADER_CODE = 2'd1;
    localparam logic [CFG_AW-1:0] REG_DATA_CODE   = 2'd2;
    localparam logic [CFG_AW-1:0] REG_FULL_CODE   = 2'd3;

    localparam logic [7:0] HEADER_CODE_RST = 8'd72;
    localparam logic [7:0] DATA_CODE_RST   = 8'd68;
    localparam logic [7:0] FULL_CODE_RST   = 8'd70;

    typedef enum logic [3:0] {
        ST_IDLE          = 4'd0,
        ST_ONLINE        = 4'd1,
        ST_HDR_ONLY_TXING = 4'd2,
        ST_HDR_TXING     = 4'd3,
        ST_RESP_TXING    = 4'd4,
        ST_FULL_TXING    = 4'd5,
        ST_WAIT_RESP     = 4'd6,
        ST_HDR_ONLY_DONE = 4'd7,
        ST_RESP_DONE     = 4'd8,
        ST_FULL_DONE     = 4'd9,
        ST_RESP_RCVD     = 4'd10
    } chan_state_t;

    // where a channel's state currently lives
    typedef enum logic [1:0] {
        TAG_IDLE,
        TAG_ONLINE,
        TAG_MEM
    } tag_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_LOOK,
        SEQ_EMIT
    } seq_state_t;

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_PID,
        PH_DATA,
        PH_SUM
    } phase_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [CH_W-1:0]   channel;
        logic [5:0]        frame_id;
        logic [2:0]        direction;
        logic              enhanced_sum;
        logic [LEN_W-1:0]  tx_length;
        logic [DATA_W-1:0] tx_data;
        logic [1:0]        rx_kind;
        logic [LEN_W-1:0]  rx_length;
        logic [DATA_W-1:0] rx_bytes;
    } in_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        out_byte;
        logic              last;
        logic [2:0]        status;
        logic [DATA_W-1:0] resp_data;
        logic [LEN_W-1:0]  resp_length;
    } out_t;

    typedef struct packed {
        logic [CH_SLOTS-1:0] enable;
        logic [7:0]          header_code;
        logic [7:0]          data_code;
        logic [7:0]          full_code;
    } cfg_t;

    typedef struct packed {
        chan_state_t       st;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } ram_word_t;

    localparam int RAM_W = $bits(ram_word_t);

    typedef struct packed {
        logic            we;
        logic [CH_W-1:0] waddr;
        ram_word_t       wdata;
        logic            re;
        logic [CH_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic            we;
        logic [CH_W-1:0] channel;
    } tag_upd_t;

endpackage

/* rtl/lmc_ram.sv */
// single-port-write, single-port-read RAM, registered read
module lmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/lmc_cfg.sv */
// configuration registers and per-channel state location tags
module lmc_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [lmc_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [lmc_pkg::CFG_W-1:0]   cfg_wdata,
    input  lmc_pkg::tag_upd_t           tag_upd,
    output lmc_pkg::cfg_t               cfg,
    output lmc_pkg::tag_t               tags [lmc_pkg::CH_SLOTS]
);

    lmc_pkg::cfg_t cfg_reg, cfg_next;
    lmc_pkg::tag_t tag_reg  [lmc_pkg::CH_SLOTS];
    lmc_pkg::tag_t tag_next [lmc_pkg::CH_SLOTS];

    // register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                lmc_pkg::REG_ENABLE:
                    cfg_next.enable = cfg_wdata[lmc_pkg::CH_SLOTS-1:0];
                lmc_pkg::REG_HEADER_CODE: cfg_next.header_code = cfg_wdata[7:0];
                lmc_pkg::REG_DATA_CODE:   cfg_next.data_code   = cfg_wdata[7:0];
                lmc_pkg::REG_FULL_CODE:   cfg_next.full_code   = cfg_wdata[7:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    // a channel that comes online is forced to online; a write-back moves
    // its state into the RAM
    always_comb begin
        for (int i = 0; i < lmc_pkg::CH_SLOTS; i++) begin
            tag_next[i] = tag_reg[i];
            if (cfg_we && cfg_addr == lmc_pkg::REG_ENABLE && cfg_wdata[i] &&
                !cfg_reg.enable[i] && i < lmc_pkg::CHANNELS) begin
                tag_next[i] = lmc_pkg::TAG_ONLINE;
            end else if (tag_upd.we && int'(tag_upd.channel) == i) begin
                tag_next[i] = lmc_pkg::TAG_MEM;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable      <= '0;
            cfg_reg.header_code <= lmc_pkg::HEADER_CODE_RST;
            cfg_reg.data_code   <= lmc_pkg::DATA_CODE_RST;
            cfg_reg.full_code   <= lmc_pkg::FULL_CODE_RST;
            for (int i = 0; i < lmc_pkg::CH_SLOTS; i++) begin
                tag_reg[i] <= lmc_pkg::TAG_IDLE;
            end
        end else begin
            cfg_reg <= cfg_next;
            for (int i = 0; i < lmc_pkg::CH_SLOTS; i++) begin
                tag_reg[i] <= tag_next[i];
            end
        end
    end

    assign cfg = cfg_reg;

    always_comb begin
        for (int i = 0; i < lmc_pkg::CH_SLOTS; i++) begin
            tags[i] = tag_reg[i];
        end
    end

endmodule

/* rtl/lmc_seq.sv */
// request sequencer: RAM read per request, frame bytes one per unstalled cycle
module lmc_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lmc_pkg::in_t         s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lmc_pkg::out_t        m_payload,
    input  lmc_pkg::cfg_t        cfg,
    input  lmc_pkg::tag_t        tags [lmc_pkg::CH_SLOTS],
    output lmc_pkg::tag_upd_t    tag_upd,
    output lmc_pkg::ram_req_t    ram_req,
    input  lmc_pkg::ram_word_t   ram_rdata
);

    // protected identifier: two parity bits over the six-bit id
    function automatic logic [7:0] protect_id(input logic [5:0] id);
        logic p0, p1;
        logic [5:0] v;
        v  = id & lmc_pkg::ID_MASK;
        p0 = v[0] ^ v[1] ^ v[2] ^ v[4];
        p1 = v[1] ^ v[3] ^ v[4] ^ v[5] ^ lmc_pkg::PARITY_INV;
        return {p1, p0, v};
    endfunction

    // 8-bit add with end-around carry
    function automatic logic [7:0] add_carry(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[7:0] + {7'd0, s[8]};
    endfunction

    function automatic logic [lmc_pkg::LEN_W-1:0] clamp_len(
        input logic [lmc_pkg::LEN_W-1:0] n);
        localparam logic [lmc_pkg::LEN_W-1:0] MaxLen =
            lmc_pkg::LEN_W'(lmc_pkg::MAX_DATA_BYTES);
        return (n > MaxLen) ? MaxLen : n;
    endfunction

    // apply a poll to one channel entry
    function automatic lmc_pkg::ram_word_t poll_apply(
        input lmc_pkg::ram_word_t         w,
        input lmc_pkg::chan_state_t       cur,
        input logic [1:0]                 rk,
        input logic [lmc_pkg::LEN_W-1:0]  rn,
        input logic [lmc_pkg::DATA_W-1:0] bytes);
        lmc_pkg::ram_word_t r;
        r    = w;
        r.st = cur;
        if (rk == lmc_pkg::RX_DATA && rn != '0) begin
            for (int i = 0; i < lmc_pkg::DATA_LANES; i++) begin
                r.data[8*i +: 8] = (i < int'(rn)) ? bytes[8*i +: 8] : 8'd0;
            end
            r.len = rn;
            if (cur == lmc_pkg::ST_HDR_ONLY_TXING) begin
                r.st = lmc_pkg::ST_HDR_ONLY_DONE;
            end else if (cur == lmc_pkg::ST_WAIT_RESP || cur == lmc_pkg::ST_HDR_TXING) begin
                r.st = lmc_pkg::ST_RESP_RCVD;
            end
        end
        unique case (r.st)
            lmc_pkg::ST_HDR_ONLY_TXING: r.st = lmc_pkg::ST_HDR_ONLY_DONE;
            lmc_pkg::ST_HDR_TXING:      r.st = lmc_pkg::ST_WAIT_RESP;
            lmc_pkg::ST_RESP_TXING:     r.st = lmc_pkg::ST_RESP_DONE;
            lmc_pkg::ST_FULL_TXING:     r.st = lmc_pkg::ST_FULL_DONE;
            default:                    r.st = r.st;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] status_of(input lmc_pkg::chan_state_t st);
        logic [2:0] s;
        unique case (st)
            lmc_pkg::ST_ONLINE:         s = lmc_pkg::STAT_OPER;
            lmc_pkg::ST_HDR_TXING,
            lmc_pkg::ST_WAIT_RESP:      s = lmc_pkg::STAT_RX_NORESP;
            lmc_pkg::ST_HDR_ONLY_TXING,
            lmc_pkg::ST_RESP_TXING,
            lmc_pkg::ST_FULL_TXING:     s = lmc_pkg::STAT_TX_BUSY;
            lmc_pkg::ST_HDR_ONLY_DONE,
            lmc_pkg::ST_RESP_DONE,
            lmc_pkg::ST_FULL_DONE:      s = lmc_pkg::STAT_TX_OK;
            lmc_pkg::ST_RESP_RCVD:      s = lmc_pkg::STAT_RX_OK;
            default:                    s = lmc_pkg::STAT_NOT_READY;
        endcase
        return s;
    endfunction

    lmc_pkg::seq_state_t seq_reg, seq_next;
    lmc_pkg::phase_t     ph_reg, ph_next, ph_after;
    lmc_pkg::in_t        req_reg, req_next;
    lmc_pkg::out_t       m_data_reg, m_data_next;
    logic                m_valid_reg, m_valid_next;
    logic [lmc_pkg::DATA_W-1:0] shift_reg, shift_next;
    logic [lmc_pkg::LEN_W-1:0]  rem_reg, rem_next;
    logic [7:0]                 sum_reg, sum_next;

    logic                        accept, out_free, ch_ok, ch_en, reject, emit_last;
    logic [7:0]                  pid, emit_byte;
    logic [lmc_pkg::LEN_W-1:0]   tx_n, rx_n;
    lmc_pkg::chan_state_t        cur_st, send_st;
    lmc_pkg::tag_t               cur_tag;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // decode of the held request and the entry just read
    always_comb begin
        ch_ok   = int'(req_reg.channel) < lmc_pkg::CHANNELS;
        ch_en   = ch_ok && cfg.enable[req_reg.channel];
        reject  = !ch_en || req_reg.direction > lmc_pkg::DIR_RESP_DATA;
        pid     = protect_id(req_reg.frame_id);
        tx_n    = clamp_len(req_reg.tx_length);
        rx_n    = clamp_len(req_reg.rx_length);
        cur_tag = tags[req_reg.channel];
        unique case (cur_tag)
            lmc_pkg::TAG_MEM:    cur_st = ram_rdata.st;
            lmc_pkg::TAG_ONLINE: cur_st = lmc_pkg::ST_ONLINE;
            default:             cur_st = lmc_pkg::ST_IDLE;
        endcase
        unique case (req_reg.direction)
            lmc_pkg::DIR_SLAVE: send_st = lmc_pkg::ST_HDR_TXING;
            lmc_pkg::DIR_S2S:   send_st = lmc_pkg::ST_HDR_ONLY_TXING;
            lmc_pkg::DIR_MASTER: send_st = lmc_pkg::ST_FULL_TXING;
            default:            send_st = lmc_pkg::ST_RESP_TXING;
        endcase
    end

    // current frame byte and the phase after it
    always_comb begin
        emit_byte = 8'd0;
        emit_last = 1'b0;
        ph_after  = ph_reg;
        unique case (ph_reg)
            lmc_pkg::PH_TYPE: begin
                if (req_reg.direction == lmc_pkg::DIR_MASTER) begin
                    emit_byte = cfg.full_code;
                    ph_after  = lmc_pkg::PH_PID;
                end else if (req_reg.direction == lmc_pkg::DIR_RESP_DATA) begin
                    emit_byte = cfg.data_code;
                    ph_after  = (rem_reg != '0) ? lmc_pkg::PH_DATA : lmc_pkg::PH_SUM;
                end else begin
                    emit_byte = cfg.header_code;
                    ph_after  = lmc_pkg::PH_PID;
                end
            end
            lmc_pkg::PH_PID: begin
                emit_byte = pid;
                if (req_reg.direction == lmc_pkg::DIR_MASTER) begin
                    ph_after = (rem_reg != '0) ? lmc_pkg::PH_DATA : lmc_pkg::PH_SUM;
                end else begin
                    emit_last = 1'b1;
                end
            end
            lmc_pkg::PH_DATA: begin
                emit_byte = shift_reg[7:0];
                if (rem_reg == lmc_pkg::LEN_W'(1)) begin
                    ph_after = lmc_pkg::PH_SUM;
                end
            end
            default: begin
                emit_byte = ~sum_reg;
                emit_last = 1'b1;
            end
        endcase
    end

    // next state
    always_comb begin
        seq_next = seq_reg;
        unique case (seq_reg)
            lmc_pkg::SEQ_IDLE: begin
                if (s_valid) begin
                    seq_next = lmc_pkg::SEQ_LOOK;
                end
            end
            lmc_pkg::SEQ_LOOK: begin
                priority if (req_reg.cmd == lmc_pkg::CMD_SEND) begin
                    if (!reject) begin
                        seq_next = lmc_pkg::SEQ_EMIT;
                    end else if (out_free) begin
                        seq_next = lmc_pkg::SEQ_IDLE;
                    end
                end else if (req_reg.cmd == lmc_pkg::CMD_QUERY) begin
                    if (out_free) begin
                        seq_next = lmc_pkg::SEQ_IDLE;
                    end
                end else begin
                    seq_next = lmc_pkg::SEQ_IDLE;
                end
            end
            default: begin
                if (out_free && emit_last) begin
                    seq_next = lmc_pkg::SEQ_IDLE;
                end
            end
        endcase
    end

    // datapath, RAM and result register
    always_comb begin
        s_ready       = (seq_reg == lmc_pkg::SEQ_IDLE);
        req_next      = accept ? s_payload : req_reg;
        ram_req.re    = accept;
        ram_req.raddr = s_payload.channel;
        ram_req.we    = 1'b0;
        ram_req.waddr = req_reg.channel;
        ram_req.wdata = ram_rdata;
        tag_upd.we      = 1'b0;
        tag_upd.channel = req_reg.channel;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        ph_next       = ph_reg;
        shift_next    = shift_reg;
        rem_next      = rem_reg;
        sum_next      = sum_reg;

        unique case (seq_reg)
            lmc_pkg::SEQ_LOOK: begin
                priority if (req_reg.cmd == lmc_pkg::CMD_SEND) begin
                    if (reject) begin
                        if (out_free) begin
                            m_valid_next     = 1'b1;
                            m_data_next      = '0;
                            m_data_next.kind = lmc_pkg::KIND_REJECT;
                            m_data_next.last = 1'b1;
                        end
                    end else begin
                        ram_req.we       = 1'b1;
                        ram_req.wdata.st = send_st;
                        tag_upd.we       = 1'b1;
                        ph_next          = lmc_pkg::PH_TYPE;
                        shift_next       = req_reg.tx_data;
                        rem_next         = tx_n;
                        sum_next         = req_reg.enhanced_sum ? pid : 8'd0;
                    end
                end else if (req_reg.cmd == lmc_pkg::CMD_POLL) begin
                    if (ch_en) begin
                        ram_req.we    = 1'b1;
                        ram_req.wdata = poll_apply(ram_rdata, cur_st, req_reg.rx_kind,
                                                   rx_n, req_reg.rx_bytes);
                        tag_upd.we    = 1'b1;
                    end
                end else if (req_reg.cmd == lmc_pkg::CMD_QUERY) begin
                    if (out_free) begin
                        m_valid_next     = 1'b1;
                        m_data_next      = '0;
                        m_data_next.kind = lmc_pkg::KIND_STATUS;
                        m_data_next.last = 1'b1;
                        if (ch_ok) begin
                            m_data_next.status = status_of(cur_st);
                            if (cur_st == lmc_pkg::ST_RESP_RCVD) begin
                                m_data_next.resp_data   = ram_rdata.data;
                                m_data_next.resp_length = ram_rdata.len;
                            end
                        end
                    end
                end else begin
                    m_valid_next = m_valid_reg && !m_ready;
                end
            end
            lmc_pkg::SEQ_EMIT: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next          = '0;
                    m_data_next.kind     = lmc_pkg::KIND_BYTE;
                    m_data_next.out_byte = emit_byte;
                    m_data_next.last     = emit_last;
                    ph_next              = ph_after;
                    if (ph_reg == lmc_pkg::PH_DATA) begin
                        shift_next = shift_reg >> 8;
                        rem_next   = rem_reg - lmc_pkg::LEN_W'(1);
                        sum_next   = add_carry(sum_reg, shift_reg[7:0]);
                    end
                end
            end
            default: begin
                ph_next = ph_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg     <= lmc_pkg::SEQ_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            seq_reg     <= seq_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        m_data_reg <= m_data_next;
        ph_reg     <= ph_next;
        shift_reg  <= shift_next;
        rem_reg    <= rem_next;
        sum_reg    <= sum_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

endmodule

/* rtl/lin_master_channel_controller.sv */
// Channel   | Direction | Handshake          | Payload
// s_        | in        | s_valid / s_ready  | lmc_pkg::in_t (send, poll, query)
// m_        | out       | m_valid / m_ready  | lmc_pkg::out_t (frame byte, status, reject)
// cfg_      | in        | cfg_we             | cfg_addr, cfg_wdata
//
// A request is taken and its channel entry is read from the state RAM; in the
// next cycle an accepted send or enabled poll modifies and writes it back. A
// query or rejected send gives one result, a send its frame bytes one per cycle
// while the output is not stalled. One request is in flight at a time on the
// single RAM port pair. Reset clears the sequencer, the result valid flag and
// the channel tags; the RAM needs no clearing pass. A stalled result holds in the output register.
module lin_master_channel_controller (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  lmc_pkg::in_t               s_payload,
    output logic                       m_valid,
    input  logic                       m_ready,
    output lmc_pkg::out_t              m_payload,
    input  logic                       cfg_we,
    input  logic [lmc_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [lmc_pkg::CFG_W-1:0]  cfg_wdata
);

    lmc_pkg::cfg_t      cfg;
    lmc_pkg::tag_t      tags [lmc_pkg::CH_SLOTS];
    lmc_pkg::tag_upd_t  tag_upd;
    lmc_pkg::ram_req_t  ram_req;
    logic [lmc_pkg::RAM_W-1:0] ram_rdata;

    lmc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .tag_upd   (tag_upd),
        .cfg       (cfg),
        .tags      (tags)
    );

    // per-channel state, length and received data
    lmc_ram #(
        .WIDTH (lmc_pkg::RAM_W),
        .DEPTH (lmc_pkg::CH_SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    lmc_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg       (cfg),
        .tags      (tags),
        .tag_upd   (tag_upd),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

endmodule

/* rtl/lmc_checker.sv */
module lmc_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input lmc_pkg::in_t               s_payload,
    input logic                       m_valid,
    input logic                       m_ready,
    input lmc_pkg::out_t              m_payload,
    input logic                       cfg_we,
    input logic [lmc_pkg::CFG_AW-1:0] cfg_addr,
    input logic [lmc_pkg::CFG_W-1:0]  cfg_wdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // a rejected send is a single result
    a_reject_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.kind == lmc_pkg::KIND_REJECT |-> m_payload.last)
        else $error("reject without last");

    // stored data is shown only with rx ok
    a_status_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.kind == lmc_pkg::KIND_STATUS &&
        m_payload.status != lmc_pkg::STAT_RX_OK |->
        m_payload.resp_data == '0 && m_payload.resp_length == '0)
        else $error("response data outside rx ok");

    // s_ready drops in the cycle after a request is taken, while its entry is read-modify-written
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken during read-modify-write");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind lin_master_channel_controller lmc_checker u_lmc_checker (.*);
